FILE: src/rti_pkg.sv
package rti_pkg;

   // default geometry formats
   localparam int COORD_BITS_DEF = 20;
   localparam int DIR_BITS_DEF   = 16;
   localparam int FAR_SCALE_DEF  = 10000000;

   localparam int COORD_FRAC = 8;
   localparam int NORM_BITS  = 16;
   localparam int QUOT_BITS  = 32;
   localparam int VERT_BITS  = 60;
   localparam int NORMAL_REG_BITS = 48;
   localparam int CSR_IDX_BITS = 3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTEX_ZERO = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTEX_ONE  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTEX_TWO  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNIT_NORMAL = 3'd3;

   // how the distance is formed at the end of the pipe
   typedef enum logic [1:0] {
      TSEL_ZERO,
      TSEL_SAT,
      TSEL_DIV
   } tsel_type;

endpackage

FILE: src/ray_triangle_intersect_core.sv
// Ray against triangle test, fully pipelined.
// Throughput is one ray per cycle.
// The depth is set by the 32-stage restoring divider that forms t, one
// quotient bit per stage. busy is always low; the receiver cannot stall.
// Synchronous active-high reset clears the configuration registers and all valid bits.
module ray_triangle_intersect_core #(
   parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
   parameter int DIR_BITS   = rti_pkg::DIR_BITS_DEF,
   parameter int FAR_SCALE  = rti_pkg::FAR_SCALE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_BITS-1:0]        req_origin_x,
   input  logic signed [COORD_BITS-1:0]        req_origin_y,
   input  logic signed [COORD_BITS-1:0]        req_origin_z,
   input  logic signed [DIR_BITS-1:0]          req_direction_x,
   input  logic signed [DIR_BITS-1:0]          req_direction_y,
   input  logic signed [DIR_BITS-1:0]          req_direction_z,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [rti_pkg::QUOT_BITS-1:0]       rsp_hit_distance,
   output logic signed [rti_pkg::NORM_BITS-1:0] rsp_normal_x,
   output logic signed [rti_pkg::NORM_BITS-1:0] rsp_normal_y,
   output logic signed [rti_pkg::NORM_BITS-1:0] rsp_normal_z,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rti_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rti_pkg::VERT_BITS-1:0]       csr_wdata
);
   import rti_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int AW   = CW + 1;
   localparam int MW   = 2 * AW + 1;
   localparam int NW   = AW + MW + 2;
   localparam int DMW  = DIR_BITS + MW + 2;
   localparam int EVW  = MW + DIR_BITS + 2;
   localparam int NUMW = AW + NORM_BITS + 2;
   localparam int DENW = DIR_BITS + NORM_BITS + 2;
   localparam int FSW  = 26;
   localparam int SH   = DIR_BITS - 2 + COORD_FRAC;
   localparam int LHSW = NW + DIR_BITS - 2;
   localparam int RHSW = DMW + FSW + COORD_FRAC;
   localparam int CMPW = ((LHSW > RHSW) ? LHSW : RHSW) + 1;
   localparam int XW   = NUMW + QUOT_BITS;
   localparam int RW   = DENW;
   localparam int NDIV = QUOT_BITS;
   localparam logic signed [FSW-1:0] FAR_S = FSW'(FAR_SCALE);

   // configuration registers
   logic [VERT_BITS-1:0]       vz_ff, vo_ff, vt_ff;
   logic [NORMAL_REG_BITS-1:0] nrm_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // write registers, drop indexes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         vz_ff  <= '0;
         vo_ff  <= '0;
         vt_ff  <= '0;
         nrm_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VERTEX_ZERO: vz_ff <= csr_wdata;
            CSR_VERTEX_ONE:  vo_ff <= csr_wdata;
            CSR_VERTEX_TWO:  vt_ff <= csr_wdata;
            CSR_UNIT_NORMAL: nrm_ff <= csr_wdata[NORMAL_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // unpack vertices
   logic [63:0] vz64, vo64, vt64;
   logic signed [CW-1:0] p0 [3];
   logic signed [CW-1:0] p1 [3];
   logic signed [CW-1:0] p2 [3];
   logic signed [CW-1:0] org [3];

   assign vz64 = {{(64-VERT_BITS){1'b0}}, vz_ff};
   assign vo64 = {{(64-VERT_BITS){1'b0}}, vo_ff};
   assign vt64 = {{(64-VERT_BITS){1'b0}}, vt_ff};
   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p0[k] = $signed(vz64[k*CW +: CW]);
         p1[k] = $signed(vo64[k*CW +: CW]);
         p2[k] = $signed(vt64[k*CW +: CW]);
      end
   end

   // stage 1: differences
   logic                        s1_v_ff;
   logic signed [AW-1:0]        a0_ff [3];
   logic signed [AW-1:0]        a1_ff [3];
   logic signed [AW-1:0]        a2_ff [3];
   logic signed [AW-1:0]        e1_ff [3];
   logic signed [AW-1:0]        e2_ff [3];
   logic signed [DIR_BITS-1:0]  d1_ff [3];
   logic signed [NORM_BITS-1:0] n1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start && !busy;
      end
      for (int k = 0; k < 3; k++) begin
         a0_ff[k] <= AW'(p0[k]) - AW'(org[k]);
         a1_ff[k] <= AW'(p1[k]) - AW'(org[k]);
         a2_ff[k] <= AW'(p2[k]) - AW'(org[k]);
         e1_ff[k] <= AW'(p1[k]) - AW'(p0[k]);
         e2_ff[k] <= AW'(p2[k]) - AW'(p0[k]);
         n1_ff[k] <= $signed(nrm_ff[k*NORM_BITS +: NORM_BITS]);
      end
      d1_ff[0] <= req_direction_x;
      d1_ff[1] <= req_direction_y;
      d1_ff[2] <= req_direction_z;
   end

   // stage 2: cross products, numerator and denominator of t
   logic                        s2_v_ff;
   logic signed [MW-1:0]        m_ff [3];
   logic signed [MW-1:0]        c01_ff [3];
   logic signed [MW-1:0]        c12_ff [3];
   logic signed [MW-1:0]        c20_ff [3];
   logic signed [AW-1:0]        a0b_ff [3];
   logic signed [DIR_BITS-1:0]  d2_ff [3];
   logic signed [NORM_BITS-1:0] n2_ff [3];
   logic signed [NUMW-1:0]      num2_ff;
   logic signed [DENW-1:0]      den2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      for (int k = 0; k < 3; k++) begin
         m_ff[k]   <= MW'(e1_ff[(k+1)%3] * e2_ff[(k+2)%3])
                    - MW'(e1_ff[(k+2)%3] * e2_ff[(k+1)%3]);
         c01_ff[k] <= MW'(a0_ff[(k+1)%3] * a1_ff[(k+2)%3])
                    - MW'(a0_ff[(k+2)%3] * a1_ff[(k+1)%3]);
         c12_ff[k] <= MW'(a1_ff[(k+1)%3] * a2_ff[(k+2)%3])
                    - MW'(a1_ff[(k+2)%3] * a2_ff[(k+1)%3]);
         c20_ff[k] <= MW'(a2_ff[(k+1)%3] * a0_ff[(k+2)%3])
                    - MW'(a2_ff[(k+2)%3] * a0_ff[(k+1)%3]);
      end
      a0b_ff <= a0_ff;
      d2_ff  <= d1_ff;
      n2_ff  <= n1_ff;
      // o - p0 is -a0
      num2_ff <= NUMW'(0) - (NUMW'(a0_ff[0] * n1_ff[0]) + NUMW'(a0_ff[1] * n1_ff[1])
                 + NUMW'(a0_ff[2] * n1_ff[2]));
      den2_ff <= DENW'(d1_ff[0] * n1_ff[0]) + DENW'(d1_ff[1] * n1_ff[1])
                 + DENW'(d1_ff[2] * n1_ff[2]);
   end

   // stage 3: plane and edge volumes
   logic                        s3_v_ff;
   logic signed [NW-1:0]        near_ff;
   logic signed [DMW-1:0]       dm_ff;
   logic [2:0]                  epos_ff, eneg_ff;
   logic signed [NORM_BITS-1:0] n3_ff [3];
   logic signed [NUMW-1:0]      num3_ff;
   logic signed [DENW-1:0]      den3_ff;
   logic signed [EVW-1:0]       ev [3];

   always_comb begin
      ev[0] = EVW'(d2_ff[0] * c01_ff[0]) + EVW'(d2_ff[1] * c01_ff[1])
            + EVW'(d2_ff[2] * c01_ff[2]);
      ev[1] = EVW'(d2_ff[0] * c12_ff[0]) + EVW'(d2_ff[1] * c12_ff[1])
            + EVW'(d2_ff[2] * c12_ff[2]);
      ev[2] = EVW'(d2_ff[0] * c20_ff[0]) + EVW'(d2_ff[1] * c20_ff[1])
            + EVW'(d2_ff[2] * c20_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      near_ff <= NW'(a0b_ff[0] * m_ff[0]) + NW'(a0b_ff[1] * m_ff[1])
               + NW'(a0b_ff[2] * m_ff[2]);
      dm_ff   <= DMW'(d2_ff[0] * m_ff[0]) + DMW'(d2_ff[1] * m_ff[1])
               + DMW'(d2_ff[2] * m_ff[2]);
      for (int k = 0; k < 3; k++) begin
         epos_ff[k] <= !ev[k][EVW-1] && (ev[k] != '0);
         eneg_ff[k] <= ev[k][EVW-1];
      end
      n3_ff   <= n2_ff;
      num3_ff <= num2_ff;
      den3_ff <= den2_ff;
   end

   // stage 4: crossing test, distance selection and divider setup
   logic signed [CMPW-1:0]      lhs, rhs, farv;
   logic                        near_pos, near_neg, far_pos, far_neg;
   logic                        edge_ok, hit_c;
   logic [NUMW-1:0]             un;
   logic [DENW-1:0]             ud;
   logic [XW-1:0]               xw;
   logic [NUMW-1:0]             xtop;
   tsel_type                    tsel_c;
   logic signed [NORM_BITS-1:0] nsel [3];
   logic                        num_zero, den_zero, num_neg, den_neg;

   always_comb begin
      lhs = CMPW'(near_ff) <<< (DIR_BITS - 2);
      rhs = CMPW'(FAR_S * dm_ff) <<< COORD_FRAC;
      farv = lhs - rhs;
      near_neg = near_ff[NW-1];
      near_pos = !near_neg && (near_ff != '0);
      far_neg  = farv[CMPW-1];
      far_pos  = !far_neg && (farv != '0);
      edge_ok  = !((epos_ff[0] && eneg_ff[1]) || (eneg_ff[0] && epos_ff[1])
                || (epos_ff[2] && eneg_ff[1]) || (eneg_ff[2] && epos_ff[1]));
      hit_c    = ((near_pos && far_neg) || (near_neg && far_pos)) && edge_ok;

      num_zero = (num3_ff == '0);
      den_zero = (den3_ff == '0);
      num_neg  = num3_ff[NUMW-1];
      den_neg  = den3_ff[DENW-1];
      un   = num_neg ? NUMW'(-num3_ff) : NUMW'(num3_ff);
      ud   = den_neg ? DENW'(-den3_ff) : DENW'(den3_ff);
      xw   = XW'(un) << SH;
      xtop = xw[XW-1:QUOT_BITS];
      if (num_zero) begin
         tsel_c = TSEL_ZERO;
      end else if (den_zero) begin
         tsel_c = TSEL_SAT;
      end else if (num_neg == den_neg) begin
         tsel_c = TSEL_ZERO;
      end else if (xtop >= NUMW'(ud)) begin
         tsel_c = TSEL_SAT;
      end else begin
         tsel_c = TSEL_DIV;
      end

      // face the normal against the ray
      for (int k = 0; k < 3; k++) begin
         if (den_neg) begin
            nsel[k] = n3_ff[k];
         end else if (n3_ff[k] == {1'b1, {(NORM_BITS-1){1'b0}}}) begin
            nsel[k] = {1'b0, {(NORM_BITS-1){1'b1}}};
         end else begin
            nsel[k] = -n3_ff[k];
         end
      end
   end

   // divider pipe, one quotient bit per stage
   logic                        dv_v_ff   [NDIV+1];
   logic                        dv_hit_ff [NDIV+1];
   tsel_type                    dv_sel_ff [NDIV+1];
   logic [RW-1:0]               dv_rem_ff [NDIV+1];
   logic [QUOT_BITS-1:0]        dv_low_ff [NDIV+1];
   logic [QUOT_BITS-1:0]        dv_q_ff   [NDIV+1];
   logic [DENW-1:0]             dv_d_ff   [NDIV+1];
   logic [3*NORM_BITS-1:0]      dv_n_ff   [NDIV+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else begin
         dv_v_ff[0] <= s3_v_ff;
      end
      dv_hit_ff[0] <= hit_c;
      dv_sel_ff[0] <= tsel_c;
      dv_rem_ff[0] <= RW'(xtop);
      dv_low_ff[0] <= xw[QUOT_BITS-1:0];
      dv_q_ff[0]   <= '0;
      dv_d_ff[0]   <= ud;
      dv_n_ff[0]   <= {nsel[2], nsel[1], nsel[0]};
   end

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      logic [RW:0]   trial;
      logic          ge;
      logic [RW-1:0] rem_nx;

      // shift in one dividend bit, subtract when it fits
      always_comb begin
         trial  = {dv_rem_ff[g], dv_low_ff[g][QUOT_BITS-1-g]};
         ge     = trial >= (RW+1)'(dv_d_ff[g]);
         rem_nx = ge ? RW'(trial - (RW+1)'(dv_d_ff[g])) : RW'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[g+1] <= 1'b0;
         end else begin
            dv_v_ff[g+1] <= dv_v_ff[g];
         end
         dv_hit_ff[g+1] <= dv_hit_ff[g];
         dv_sel_ff[g+1] <= dv_sel_ff[g];
         dv_rem_ff[g+1] <= rem_nx;
         dv_low_ff[g+1] <= dv_low_ff[g];
         dv_q_ff[g+1]   <= {dv_q_ff[g][QUOT_BITS-2:0], ge};
         dv_d_ff[g+1]   <= dv_d_ff[g];
         dv_n_ff[g+1]   <= dv_n_ff[g];
      end
   end

   // output word register
   logic                        out_v_ff, out_hit_ff;
   logic [QUOT_BITS-1:0]        out_t_ff, t_in;
   logic [3*NORM_BITS-1:0]      out_n_ff;

   always_comb begin
      case (dv_sel_ff[NDIV])
         TSEL_ZERO: t_in = '0;
         TSEL_SAT:  t_in = '1;
         TSEL_DIV:  t_in = dv_q_ff[NDIV];
         default:   t_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= dv_v_ff[NDIV];
      end
      out_hit_ff <= dv_hit_ff[NDIV];
      out_t_ff   <= dv_hit_ff[NDIV] ? t_in : '0;
      out_n_ff   <= dv_hit_ff[NDIV] ? dv_n_ff[NDIV] : '0;
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_hit          = out_hit_ff;
   assign rsp_hit_distance = out_t_ff;
   assign rsp_normal_x     = $signed(out_n_ff[NORM_BITS-1:0]);
   assign rsp_normal_y     = $signed(out_n_ff[2*NORM_BITS-1:NORM_BITS]);
   assign rsp_normal_z     = $signed(out_n_ff[3*NORM_BITS-1:2*NORM_BITS]);

endmodule
